[rtl/core/seq_pkg.sv]
// ----------------------------------------------------------------------------
// seq_pkg: shared types and constants of the sorted event queue
// Entry layout, memory port bundle, operation and status codes, and the
// sequencer states.
// ----------------------------------------------------------------------------
package seq_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int TAG_BITS    = 16;
   localparam int KEY_BITS    = 40;
   localparam int POS_BITS    = 7;
   localparam int ECNT_BITS   = 7;

   localparam int ADDR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS  = $clog2(QUEUE_DEPTH + 1);
   localparam int CMP_BITS  = (CNT_BITS > POS_BITS) ? CNT_BITS : POS_BITS;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_PEEK   = 2'd1,
      OP_POP    = 2'd2,
      OP_MODIFY = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_FULL   = 2'd2,
      ST_BADPOS = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT_UP,
      S_PLACE,
      S_HEAD,
      S_SHIFT_DOWN
   } state_type;

   typedef struct packed {
      logic [KEY_BITS-1:0] key;
      logic [TAG_BITS-1:0] desc;
      logic [TAG_BITS-1:0] prio;
   } entry_type;

   typedef struct packed {
      logic                 wr_en;
      logic [ADDR_BITS-1:0] wr_addr;
      entry_type            wr_data;
      logic [ADDR_BITS-1:0] rd_addr;
   } mem_req_type;

endpackage

[rtl/core/seq_store.sv]
// ----------------------------------------------------------------------------
// seq_store: entry memory of the sorted event queue
// One write port and one read port per cycle; read data is registered.
// ----------------------------------------------------------------------------
module seq_store (
   input  logic                clock,
   input  seq_pkg::mem_req_type mem_req,
   output seq_pkg::entry_type  rd_data
);

   seq_pkg::entry_type store_ff [seq_pkg::QUEUE_DEPTH];
   seq_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         store_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      rd_data_ff <= store_ff[mem_req.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/sorted_event_queue.sv]
// ----------------------------------------------------------------------------
// sorted_event_queue: bounded time-ordered event queue
// Keeps up to QUEUE_DEPTH entries in ascending key order in one memory.
// ----------------------------------------------------------------------------
// Usage:
//   Present a command on the req_ ports with start high; it is taken at a
//   rising edge where busy is low. busy stays high while the sequencer walks
//   the entry memory. Exactly one result per command appears on the rsp_
//   ports for one cycle with rsp_strobe high; it cannot be held off.
// Steps (N = entries stored before the command):
//   modify, and any command reporting full, empty or bad position: answered from idle
//   peek: head read; pop: head read, then (N > 1) a move of entries 1..N-1 down by one
//   insert: direct write if empty, else forward scan for the slot, then a move of
//   the tail (if any) up by one, each move step one memory read and one write
// All walks share the single read and write port of the entry memory and
// one key comparator. A new command may be issued in the cycle the result
// strobe is high. Reset empties the queue; memory contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_event_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_operation,
   input  logic [seq_pkg::KEY_BITS-1:0] req_time_key,
   input  logic [seq_pkg::TAG_BITS-1:0] req_description_tag,
   input  logic [seq_pkg::TAG_BITS-1:0] req_priority_tag,
   input  logic [seq_pkg::POS_BITS-1:0] req_position,
   output logic                         rsp_strobe,
   output logic [1:0]                   rsp_status,
   output logic [seq_pkg::KEY_BITS-1:0] rsp_entry_key,
   output logic [seq_pkg::TAG_BITS-1:0] rsp_entry_description,
   output logic [seq_pkg::TAG_BITS-1:0] rsp_entry_priority,
   output logic [seq_pkg::ECNT_BITS-1:0] rsp_entry_count
);

   localparam int CB = seq_pkg::CNT_BITS;
   localparam int AB = seq_pkg::ADDR_BITS;

   seq_pkg::state_type   state_ff, state_in;
   logic [CB-1:0]        count_ff, count_in;
   logic [CB-1:0]        chk_ff, chk_in;
   logic [CB-1:0]        slot_ff, slot_in;
   seq_pkg::op_type      op_ff, op_in;
   seq_pkg::entry_type   new_ff, new_in;
   seq_pkg::entry_type   rsp_data_ff, rsp_data_in;
   seq_pkg::status_type  rsp_status_ff, rsp_status_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;

   seq_pkg::mem_req_type mem_req;
   seq_pkg::entry_type   rd_data;

   logic [CB-1:0]                chk_inc, chk_dec, count_dec;
   logic [seq_pkg::CMP_BITS-1:0] pos_ext, pos_idx, count_ext;
   logic                         pos_ok;
   seq_pkg::entry_type           req_entry;

   seq_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   assign chk_inc   = CB'(chk_ff + 1'b1);
   assign chk_dec   = CB'(chk_ff - 1'b1);
   assign count_dec = CB'(count_ff - 1'b1);
   assign pos_ext   = seq_pkg::CMP_BITS'(req_position);
   assign pos_idx   = seq_pkg::CMP_BITS'(pos_ext - 1'b1);
   assign count_ext = seq_pkg::CMP_BITS'(count_ff);
   assign pos_ok    = (pos_ext != '0) && (pos_ext <= count_ext);

   assign req_entry.key  = req_time_key;
   assign req_entry.desc = req_description_tag;
   assign req_entry.prio = req_priority_tag;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= seq_pkg::S_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_ff        <= chk_in;
      slot_ff       <= slot_in;
      op_ff         <= op_in;
      new_ff        <= new_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      chk_in           = chk_ff;
      slot_in          = slot_ff;
      op_in            = op_ff;
      new_in           = new_ff;
      rsp_data_in      = rsp_data_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_strobe_in    = 1'b0;
      mem_req.wr_en    = 1'b0;
      mem_req.wr_addr  = '0;
      mem_req.wr_data  = new_ff;
      mem_req.rd_addr  = '0;

      case (state_ff)
         seq_pkg::S_IDLE: begin
            if (start) begin
               new_in = req_entry;
               op_in  = seq_pkg::op_type'(req_operation);
               case (seq_pkg::op_type'(req_operation))
                  seq_pkg::OP_INSERT: begin
                     if (count_ext == seq_pkg::CMP_BITS'(seq_pkg::QUEUE_DEPTH)) begin
                        rsp_status_in = seq_pkg::ST_FULL;
                        rsp_data_in   = '0;
                        rsp_strobe_in = 1'b1;
                     end else if (count_ff == '0) begin
                        slot_in  = '0;
                        state_in = seq_pkg::S_PLACE;
                     end else begin
                        chk_in   = '0;
                        state_in = seq_pkg::S_SCAN;
                     end
                  end
                  seq_pkg::OP_PEEK, seq_pkg::OP_POP: begin
                     if (count_ff == '0) begin
                        rsp_status_in = seq_pkg::ST_EMPTY;
                        rsp_data_in   = '0;
                        rsp_strobe_in = 1'b1;
                     end else begin
                        state_in = seq_pkg::S_HEAD;
                     end
                  end
                  seq_pkg::OP_MODIFY: begin
                     rsp_data_in   = '0;
                     rsp_strobe_in = 1'b1;
                     if (pos_ok) begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = pos_idx[AB-1:0];
                        mem_req.wr_data = req_entry;
                        rsp_status_in   = seq_pkg::ST_OK;
                     end else begin
                        rsp_status_in = seq_pkg::ST_BADPOS;
                     end
                  end
                  default: begin
                     rsp_status_in = seq_pkg::ST_BADPOS;
                  end
               endcase
            end
         end

         // find the first entry whose key is strictly greater
         seq_pkg::S_SCAN: begin
            if (rd_data.key > new_ff.key) begin
               slot_in         = chk_ff;
               chk_in          = count_dec;
               mem_req.rd_addr = count_dec[AB-1:0];
               state_in        = seq_pkg::S_SHIFT_UP;
            end else if (chk_inc == count_ff) begin
               slot_in  = count_ff;
               state_in = seq_pkg::S_PLACE;
            end else begin
               chk_in          = chk_inc;
               mem_req.rd_addr = chk_inc[AB-1:0];
            end
         end

         // move entries slot..count-1 up by one, top first
         seq_pkg::S_SHIFT_UP: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = chk_inc[AB-1:0];
            mem_req.wr_data = rd_data;
            if (chk_ff == slot_ff) begin
               state_in = seq_pkg::S_PLACE;
            end else begin
               chk_in          = chk_dec;
               mem_req.rd_addr = chk_dec[AB-1:0];
            end
         end

         seq_pkg::S_PLACE: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = slot_ff[AB-1:0];
            mem_req.wr_data = new_ff;
            count_in        = CB'(count_ff + 1'b1);
            rsp_status_in   = seq_pkg::ST_OK;
            rsp_data_in     = '0;
            rsp_strobe_in   = 1'b1;
            state_in        = seq_pkg::S_IDLE;
         end

         seq_pkg::S_HEAD: begin
            rsp_data_in   = rd_data;
            rsp_status_in = seq_pkg::ST_OK;
            if (op_ff == seq_pkg::OP_POP && count_ff != CB'(1)) begin
               chk_in          = CB'(1);
               mem_req.rd_addr = AB'(1);
               state_in        = seq_pkg::S_SHIFT_DOWN;
            end else begin
               if (op_ff == seq_pkg::OP_POP) begin
                  count_in = count_dec;
               end
               rsp_strobe_in = 1'b1;
               state_in      = seq_pkg::S_IDLE;
            end
         end

         // move entries 1..count-1 down by one, head side first
         seq_pkg::S_SHIFT_DOWN: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = chk_dec[AB-1:0];
            mem_req.wr_data = rd_data;
            if (chk_ff == count_dec) begin
               count_in      = count_dec;
               rsp_strobe_in = 1'b1;
               state_in      = seq_pkg::S_IDLE;
            end else begin
               chk_in          = chk_inc;
               mem_req.rd_addr = chk_inc[AB-1:0];
            end
         end

         default: begin
            state_in = seq_pkg::S_IDLE;
         end
      endcase
   end

   assign busy                  = (state_ff != seq_pkg::S_IDLE);
   assign rsp_strobe            = rsp_strobe_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_entry_key         = rsp_data_ff.key;
   assign rsp_entry_description = rsp_data_ff.desc;
   assign rsp_entry_priority    = rsp_data_ff.prio;
   assign rsp_entry_count       = count_ext[seq_pkg::ECNT_BITS-1:0];

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ext <= seq_pkg::CMP_BITS'(seq_pkg::QUEUE_DEPTH))
      else $error("entry count above queue depth");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while sequencer still busy");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe))
      else $error("accepted command neither started nor answered");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(count_ff)) |->
         (count_ff == CB'($past(count_ff) + 1'b1) ||
          count_ff == CB'($past(count_ff) - 1'b1)))
      else $error("entry count changed by more than one");

   a_count_on_strobe: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(count_ff)) |-> rsp_strobe)
      else $error("entry count changed without a result");
`endif

endmodule
